// ===== hdl/dwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_pkg
// Types and codes shared by the depthwise convolution engine.
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int MAX_ROWS     = 32;
  localparam int MAX_COLS     = 32;
  localparam int MAX_CHANNELS = 32;
  localparam int MAX_KERNEL   = 8;

  localparam logic [1:0] ACT_LOAD_ACT = 2'd0;
  localparam logic [1:0] ACT_LOAD_WGT = 2'd1;
  localparam logic [1:0] ACT_RUN      = 2'd2;
  localparam logic [1:0] ACT_READ     = 2'd3;

  localparam logic [2:0] REG_IN_ROWS  = 3'd0;
  localparam logic [2:0] REG_IN_COLS  = 3'd1;
  localparam logic [2:0] REG_OUT_ROWS = 3'd2;
  localparam logic [2:0] REG_OUT_COLS = 3'd3;
  localparam logic [2:0] REG_KER_ROWS = 3'd4;
  localparam logic [2:0] REG_KER_COLS = 3'd5;
  localparam logic [2:0] REG_ROW_STEP = 3'd6;
  localparam logic [2:0] REG_COL_STEP = 3'd7;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 6;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [4:0]         channel;
    logic signed [15:0] value;
    logic [2:0]         pad_top;
    logic [2:0]         pad_left;
    logic [5:0]         channel_count;
    logic [4:0]         input_channel_offset;
    logic [4:0]         weight_channel_offset;
    logic               accumulate;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] read_data;
    logic [1:0]         completed_action;
  } out_item_t;

endpackage

// ===== hdl/dwc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_mac
// Registered multiply, then saturating accumulate of one tap.
// ----------------------------------------------------------------------------
module dwc_mac #(
  parameter int DATA_BITS = 16,
  parameter int ACC_BITS  = 40
) (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic signed [ACC_BITS-1:0]  init_i,
  input  logic                        tap_i,
  input  logic signed [DATA_BITS-1:0] act_i,
  input  logic signed [DATA_BITS-1:0] wgt_i,
  output logic signed [ACC_BITS-1:0]  acc_o
);
  localparam int PB = 2 * DATA_BITS;
  localparam int SB = (PB > ACC_BITS ? PB : ACC_BITS) + 1;
  localparam logic signed [SB-1:0] AMAX = SB'(({ACC_BITS{1'b1}}) >> 1);
  localparam logic signed [SB-1:0] AMIN = -AMAX - SB'(1);

  logic signed [PB-1:0]       prod_q;
  logic                       pv_q;
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic signed [SB-1:0]       p_c, sum;

  always_comb begin
    p_c = SB'(prod_q);
    if (p_c > AMAX) p_c = AMAX;
    if (p_c < AMIN) p_c = AMIN;
    sum = SB'(acc_q) + p_c;
    if (sum > AMAX) sum = AMAX;
    if (sum < AMIN) sum = AMIN;
    acc_d = acc_q;
    if (pv_q) acc_d = ACC_BITS'(sum);
    if (start_i) acc_d = init_i;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PB'(act_i) * PB'(wgt_i);
    pv_q   <= tap_i;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;
endmodule

// ===== hdl/depthwise_conv2d_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depthwise_conv2d_engine_unit
// Depthwise 2D convolution over on-chip activation, weight and result memories.
// ----------------------------------------------------------------------------
// Load items stream back to back while the output is not stalled. A read
// item holds the input while its result is fetched, so a read is not followed
// by another item back to back. A run walks output row, column and channel;
// per output it reads the old result in S_INIT, steps through the kernel taps
// in S_TAP (the single activation/weight read port pair sets this), drains the
// pipeline through S_DR1, S_DR2 and S_DR3 and writes back in S_WB. Each size
// is clipped to its maximum. A run that computes nothing completes at once.
module depthwise_conv2d_engine_unit #(
  parameter int DATA_BITS    = 16,
  parameter int ACC_BITS     = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dwc_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dwc_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [dwc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [dwc_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);
  import dwc_pkg::*;

  localparam int RB = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CB = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int HB = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
  localparam int KB = MAX_KERNEL > 1 ? $clog2(MAX_KERNEL) : 1;
  localparam int AB = RB + CB + HB;
  localparam int WB = 2 * KB + HB;
  localparam int VB = DATA_BITS < 16 ? DATA_BITS : 16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_TAP  = 3'd2;
  localparam logic [2:0] S_DR1  = 3'd3;
  localparam logic [2:0] S_DR2  = 3'd4;
  localparam logic [2:0] S_DR3  = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;

  logic signed [DATA_BITS-1:0] act_mem [2**AB];
  logic signed [DATA_BITS-1:0] wgt_mem [2**WB];
  logic signed [ACC_BITS-1:0]  res_mem [2**AB];

  logic [5:0] in_rows_q, in_cols_q, out_rows_q, out_cols_q;
  logic [3:0] kr_n_q, kc_n_q;
  logic [2:0] rs_q, cs_q;

  logic [2:0] st_q;
  logic [5:0] r_q, c_q, k_q, cnt_q;
  logic [4:0] kr_q, kc_q;
  logic [7:0] ioff_q, woff_q;
  logic [2:0] pt_q, pl_q;
  logic       accum_q;

  logic signed [DATA_BITS-1:0] act_rd_q, wgt_rd_q;
  logic                        inb_q;
  logic signed [ACC_BITS-1:0]  res_rd_q;
  logic                        tap_v_q;

  logic        ovalid_q, rd_pend_q;
  logic [1:0]  oact_q;
  logic        rd_ok_q;

  function automatic logic [6:0] lim(input logic [6:0] v, input int m);
    lim = (int'(v) > m) ? 7'(m) : v;
  endfunction

  // ---- limits
  logic [6:0] ir_n, ic_n, or_n, oc_n, kr_n, kc_n, cnt_n;
  assign ir_n  = lim(7'(in_rows_q), MAX_ROWS);
  assign ic_n  = lim(7'(in_cols_q), MAX_COLS);
  assign or_n  = lim(7'(out_rows_q), MAX_ROWS);
  assign oc_n  = lim(7'(out_cols_q), MAX_COLS);
  assign kr_n  = lim(7'(kr_n_q), MAX_KERNEL);
  assign kc_n  = lim(7'(kc_n_q), MAX_KERNEL);
  assign cnt_n = lim(7'(in_data_i.channel_count), MAX_CHANNELS);

  // ---- handshake
  logic out_free, accept;
  assign out_free   = !ovalid_q || (!out_stall_i && !rd_pend_q);
  assign in_stall_o = (st_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // ---- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rows_q <= 6'd32; in_cols_q <= 6'd32; out_rows_q <= 6'd32; out_cols_q <= 6'd32;
      kr_n_q <= 4'd3; kc_n_q <= 4'd3; rs_q <= 3'd1; cs_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IN_ROWS:  in_rows_q  <= cfg_wdata_i;
        REG_IN_COLS:  in_cols_q  <= cfg_wdata_i;
        REG_OUT_ROWS: out_rows_q <= cfg_wdata_i;
        REG_OUT_COLS: out_cols_q <= cfg_wdata_i;
        REG_KER_ROWS: kr_n_q     <= cfg_wdata_i[3:0];
        REG_KER_COLS: kc_n_q     <= cfg_wdata_i[3:0];
        REG_ROW_STEP: rs_q       <= cfg_wdata_i[2:0];
        REG_COL_STEP: cs_q       <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // ---- addresses
  logic [6:0] ach7, wch7;
  logic [HB-1:0] ach, wch, kch;
  assign ach7 = 7'(ioff_q) + 7'(k_q);
  assign wch7 = 7'(woff_q) + 7'(k_q);
  assign ach  = HB'(ach7 % 7'(MAX_CHANNELS));
  assign wch  = HB'(wch7 % 7'(MAX_CHANNELS));
  assign kch  = HB'(k_q);

  logic signed [12:0] y, x;
  logic               tap_in;
  assign y = 13'(r_q) * 13'(rs_q) + 13'(kr_q) - 13'(pt_q);
  assign x = 13'(c_q) * 13'(cs_q) + 13'(kc_q) - 13'(pl_q);
  assign tap_in = (y >= 0) && (y < 13'(ir_n)) && (x >= 0) && (x < 13'(ic_n));

  logic [AB-1:0] act_ra, res_a, ld_a;
  logic [WB-1:0] wgt_ra, ld_w;
  assign act_ra = {RB'(y), CB'(x), ach};
  assign wgt_ra = {KB'(kr_q), KB'(kc_q), wch};
  assign res_a  = {RB'(r_q), CB'(c_q), kch};
  assign ld_a   = {RB'(in_data_i.row), CB'(in_data_i.col), HB'(in_data_i.channel)};
  assign ld_w   = {KB'(in_data_i.row), KB'(in_data_i.col), HB'(in_data_i.channel)};

  logic act_ok, wgt_ok;
  assign act_ok = (int'(in_data_i.row) < MAX_ROWS) && (int'(in_data_i.col) < MAX_COLS)
               && (int'(in_data_i.channel) < MAX_CHANNELS);
  assign wgt_ok = (int'(in_data_i.row) < MAX_KERNEL) && (int'(in_data_i.col) < MAX_KERNEL)
               && (int'(in_data_i.channel) < MAX_CHANNELS);

  logic signed [ACC_BITS-1:0] acc;
  logic                       mac_start;
  assign mac_start = (st_q == S_TAP) && (kr_q == 5'd0) && (kc_q == 5'd0);

  logic empty_kernel;
  assign empty_kernel = (kr_n == 7'd0) || (kc_n == 7'd0);

  logic signed [ACC_BITS-1:0] init_v;
  assign init_v = accum_q ? res_rd_q : '0;

  // Empty kernel: pass the initial value straight to write-back.
  logic empty_start_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) empty_start_q <= 1'b0;
    else empty_start_q <= (st_q == S_INIT) && empty_kernel;
  end
  logic signed [ACC_BITS-1:0] wb_val;
  logic signed [ACC_BITS-1:0] empty_val_q;
  always_ff @(posedge clk_i) if (empty_start_q) empty_val_q <= init_v;
  logic empty_run_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) empty_run_q <= 1'b0;
    else if (st_q == S_INIT) empty_run_q <= empty_kernel;
  end
  assign wb_val = empty_run_q ? empty_val_q : acc;

  // ---- memories
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.action == ACT_LOAD_ACT && act_ok)
      act_mem[ld_a] <= DATA_BITS'($signed(in_data_i.value[VB-1:0]));
    if (accept && in_data_i.action == ACT_LOAD_WGT && wgt_ok)
      wgt_mem[ld_w] <= DATA_BITS'($signed(in_data_i.value[VB-1:0]));
    act_rd_q <= act_mem[act_ra];
    wgt_rd_q <= wgt_mem[wgt_ra];
    inb_q    <= tap_in;
    if (st_q == S_WB) res_mem[res_a] <= wb_val;
    res_rd_q <= (st_q == S_IDLE) ? res_mem[ld_a] : res_mem[res_a];
  end

  dwc_mac #(.DATA_BITS(DATA_BITS), .ACC_BITS(ACC_BITS)) u_mac (
    .clk_i   (clk_i),
    .start_i (mac_start),
    .init_i  (init_v),
    .tap_i   (tap_v_q),
    .act_i   (inb_q ? act_rd_q : '0),
    .wgt_i   (wgt_rd_q),
    .acc_o   (acc)
  );

  // ---- sequencer
  logic last_kc, last_kr, last_k, last_c, last_r;
  assign last_kc = (7'(kc_q) + 7'd1 >= kc_n);
  assign last_kr = (7'(kr_q) + 7'd1 >= kr_n);
  assign last_k  = (7'(k_q) + 7'd1 >= 7'(cnt_q));
  assign last_c  = (7'(c_q) + 7'd1 >= oc_n);
  assign last_r  = (7'(r_q) + 7'd1 >= or_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; tap_v_q <= 1'b0;
      r_q <= '0; c_q <= '0; k_q <= '0; kr_q <= '0; kc_q <= '0;
      cnt_q <= '0; ioff_q <= '0; woff_q <= '0; pt_q <= '0; pl_q <= '0; accum_q <= 1'b0;
    end else begin
      tap_v_q <= (st_q == S_TAP);
      unique case (st_q)
        S_IDLE: begin
          if (accept && in_data_i.action == ACT_RUN) begin
            r_q <= '0; c_q <= '0; k_q <= '0; kr_q <= '0; kc_q <= '0;
            cnt_q <= 6'(cnt_n);
            ioff_q <= 8'(in_data_i.input_channel_offset);
            woff_q <= 8'(in_data_i.weight_channel_offset);
            pt_q <= in_data_i.pad_top; pl_q <= in_data_i.pad_left;
            accum_q <= in_data_i.accumulate;
            if (cnt_n != 7'd0 && or_n != 7'd0 && oc_n != 7'd0) st_q <= S_INIT;
          end
        end
        S_INIT: st_q <= empty_kernel ? S_DR1 : S_TAP;
        S_TAP: begin
          if (!last_kc) kc_q <= kc_q + 5'd1;
          else begin
            kc_q <= '0;
            if (!last_kr) kr_q <= kr_q + 5'd1;
            else begin kr_q <= '0; st_q <= S_DR1; end
          end
        end
        S_DR1: st_q <= S_DR2;
        S_DR2: st_q <= S_DR3;
        S_DR3: st_q <= S_WB;
        S_WB: begin
          st_q <= (last_k && last_c && last_r) ? S_IDLE : S_INIT;
          if (!last_k) k_q <= k_q + 6'd1;
          else begin
            k_q <= '0;
            if (!last_c) c_q <= c_q + 6'd1;
            else begin
              c_q <= '0;
              if (!last_r) r_q <= r_q + 6'd1;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // ---- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0; rd_pend_q <= 1'b0; oact_q <= ACT_LOAD_ACT; rd_ok_q <= 1'b0;
    end else begin
      rd_pend_q <= accept && (in_data_i.action == ACT_READ);
      if (accept && in_data_i.action != ACT_RUN) begin
        ovalid_q <= 1'b1; oact_q <= in_data_i.action;
        rd_ok_q <= act_ok;
      end else if (st_q == S_WB && last_k && last_c && last_r) begin
        ovalid_q <= 1'b1; oact_q <= ACT_RUN;
      end else if (accept && in_data_i.action == ACT_RUN
                   && (cnt_n == 7'd0 || or_n == 7'd0 || oc_n == 7'd0)) begin
        ovalid_q <= 1'b1; oact_q <= ACT_RUN;
      end else if (out_free) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Capture read data in the cycle after the item is taken.
  logic signed [39:0] rd_hold_q;
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) rd_hold_q <= rd_ok_q ? 40'(res_rd_q) : '0;
  end

  assign out_valid_o = ovalid_q && !rd_pend_q;
  assign out_data_o.read_data = (oact_q == ACT_READ) ? rd_hold_q : '0;
  assign out_data_o.completed_action = oact_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> in_stall_o) else $error("input taken during run");
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_o) else $error("read shown before data");
  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(accept)) else $error("stray read pending");
`endif
endmodule

// ===== tb/depthwise_conv2d_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depthwise_conv2d_engine_unit_tb
// Self-checking bench for the depthwise convolution engine: loads, runs and
// reads are predicted by a behavioral convolution model and each returned
// item is compared field by field, under random valid/stall gaps.
// ----------------------------------------------------------------------------
module depthwise_conv2d_engine_unit_tb;
  import dwc_pkg::*;

  localparam int NR = 32;
  localparam int NC = 32;
  localparam int NCH = 32;
  localparam int NK = 8;
  localparam longint ACC_HI = (longint'(1) <<< 39) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< 39);
  localparam int CYCLE_LIMIT = 20000000;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  depthwise_conv2d_engine_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  logic signed [15:0] act_mem [NR*NC*NCH];
  bit act_ok [NR*NC*NCH];
  logic signed [15:0] wgt_mem [NK*NK*NCH];
  bit wgt_ok [NK*NK*NCH];
  longint res_mem [NR*NC*NCH];
  bit res_ok [NR*NC*NCH];
  int res_list [$];
  logic [5:0] geom [8];

  out_item_t expected_q [$];
  int errors;
  int items_sent;
  int send_pct;
  int recv_pct;
  int cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int clip(int v, int m);
    return (v > m) ? m : v;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic void convolve(in_item_t it);
    int or_n, oc_n, ir_n, ic_n, kr_n, kc_n, cnt, ach, wch, ri, y, x;
    longint acc, a, w;
    or_n = clip(geom[REG_OUT_ROWS], NR);
    oc_n = clip(geom[REG_OUT_COLS], NC);
    ir_n = clip(geom[REG_IN_ROWS], NR);
    ic_n = clip(geom[REG_IN_COLS], NC);
    kr_n = clip(geom[REG_KER_ROWS], NK);
    kc_n = clip(geom[REG_KER_COLS], NK);
    cnt = clip(it.channel_count, NCH);
    for (int r = 0; r < or_n; r++)
      for (int c = 0; c < oc_n; c++)
        for (int k = 0; k < cnt; k++) begin
          ach = (int'(it.input_channel_offset) + k) % NCH;
          wch = (int'(it.weight_channel_offset) + k) % NCH;
          ri = (r * NC + c) * NCH + k;
          acc = it.accumulate ? res_mem[ri] : 0;
          for (int kr = 0; kr < kr_n; kr++)
            for (int kc = 0; kc < kc_n; kc++) begin
              y = r * int'(geom[REG_ROW_STEP]) + kr - int'(it.pad_top);
              x = c * int'(geom[REG_COL_STEP]) + kc - int'(it.pad_left);
              a = 0;
              if (y >= 0 && y < ir_n && x >= 0 && x < ic_n)
                a = act_mem[(y * NC + x) * NCH + ach];
              w = wgt_mem[(kr * NK + kc) * NCH + wch];
              acc = sat_sum(acc, a * w);
            end
          res_mem[ri] = acc;
          if (!res_ok[ri]) begin
            res_ok[ri] = 1'b1;
            res_list.push_back(ri);
          end
        end
  endfunction

  function automatic out_item_t engine_step(in_item_t it);
    out_item_t o;
    int idx;
    o.read_data = '0;
    o.completed_action = it.action;
    idx = (int'(it.row) * NC + int'(it.col)) * NCH + int'(it.channel);
    case (it.action)
      ACT_LOAD_ACT: begin
        act_mem[idx] = it.value;
        act_ok[idx] = 1'b1;
      end
      ACT_LOAD_WGT: begin
        if (it.row < NK && it.col < NK) begin
          idx = (int'(it.row) * NK + int'(it.col)) * NCH + int'(it.channel);
          wgt_mem[idx] = it.value;
          wgt_ok[idx] = 1'b1;
        end
      end
      ACT_RUN: convolve(it);
      default: o.read_data = res_mem[idx][39:0];
    endcase
    return o;
  endfunction

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    expected_q.push_back(engine_step(it));
    items_sent++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: read_data %0d completed_action %0d",
               out_data.read_data, out_data.completed_action);
        errors++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_data.read_data !== exp_item.read_data) begin
          $error("read_data: expected %0d, actual %0d", exp_item.read_data,
                 out_data.read_data);
          errors++;
        end
        if (out_data.completed_action !== exp_item.completed_action) begin
          $error("completed_action: expected %0d, actual %0d",
                 exp_item.completed_action, out_data.completed_action);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("depthwise_conv2d_engine_unit_tb failed");
      $finish;
    end
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_geometry(input logic [5:0] v [8]);
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= i[2:0];
      cfg_wdata <= v[i];
      @(posedge clk_i);
      geom[i] = v[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t rand_item(logic [1:0] act);
    in_item_t it;
    logic [63:0] bits_r;
    bits_r = {$urandom, $urandom};
    it = bits_r[$bits(in_item_t)-1:0];
    it.action = act;
    return it;
  endfunction

  // load every tap the run will touch that was never written, drop
  // accumulate when an old result is missing
  task automatic prepare_run(inout in_item_t it);
    int or_n, oc_n, ir_n, ic_n, kr_n, kc_n, cnt, ach, wch, y, x;
    in_item_t ld;
    or_n = clip(geom[REG_OUT_ROWS], NR);
    oc_n = clip(geom[REG_OUT_COLS], NC);
    ir_n = clip(geom[REG_IN_ROWS], NR);
    ic_n = clip(geom[REG_IN_COLS], NC);
    kr_n = clip(geom[REG_KER_ROWS], NK);
    kc_n = clip(geom[REG_KER_COLS], NK);
    cnt = clip(it.channel_count, NCH);
    for (int r = 0; r < or_n; r++)
      for (int c = 0; c < oc_n; c++)
        for (int k = 0; k < cnt; k++) begin
          ach = (int'(it.input_channel_offset) + k) % NCH;
          wch = (int'(it.weight_channel_offset) + k) % NCH;
          if (!res_ok[(r * NC + c) * NCH + k]) it.accumulate = 1'b0;
          for (int kr = 0; kr < kr_n; kr++)
            for (int kc = 0; kc < kc_n; kc++) begin
              y = r * int'(geom[REG_ROW_STEP]) + kr - int'(it.pad_top);
              x = c * int'(geom[REG_COL_STEP]) + kc - int'(it.pad_left);
              if (y >= 0 && y < ir_n && x >= 0 && x < ic_n &&
                  !act_ok[(y * NC + x) * NCH + ach]) begin
                ld = rand_item(ACT_LOAD_ACT);
                ld.row = y[4:0];
                ld.col = x[4:0];
                ld.channel = ach[4:0];
                send_item(ld);
              end
              if (!wgt_ok[(kr * NK + kc) * NCH + wch]) begin
                ld = rand_item(ACT_LOAD_WGT);
                ld.row = kr[4:0];
                ld.col = kc[4:0];
                ld.channel = wch[4:0];
                send_item(ld);
              end
            end
        end
  endtask

  task automatic run_checked(in_item_t it);
    prepare_run(it);
    send_item(it);
  endtask

  task automatic read_some(int n);
    in_item_t it;
    int ri;
    for (int i = 0; i < n && res_list.size() != 0; i++) begin
      ri = res_list[$urandom_range(res_list.size() - 1)];
      it = rand_item(ACT_READ);
      it.row = ri[14:10];
      it.col = ri[9:5];
      it.channel = ri[4:0];
      send_item(it);
    end
  endtask

  task automatic test_directed();
    logic [5:0] g [8];
    in_item_t it;
    g = '{6'd4, 6'd4, 6'd3, 6'd3, 6'd2, 6'd2, 6'd1, 6'd1};
    write_geometry(g);
    it = rand_item(ACT_LOAD_ACT);
    it.row = 5'd31; it.col = 5'd31; it.channel = 5'd31; it.value = 16'sh7fff;
    send_item(it);
    it = rand_item(ACT_LOAD_ACT);
    it.row = 5'd0; it.col = 5'd0; it.channel = 5'd0; it.value = 16'sh8000;
    send_item(it);
    it = rand_item(ACT_LOAD_WGT);
    it.row = 5'd31; it.col = 5'd9; it.channel = 5'd3;
    send_item(it);
    it = rand_item(ACT_LOAD_WGT);
    it.row = 5'd7; it.col = 5'd7; it.channel = 5'd31; it.value = 16'sh8000;
    send_item(it);
    it = rand_item(ACT_RUN);
    it.pad_top = 3'd7; it.pad_left = 3'd7; it.channel_count = 6'd2;
    it.input_channel_offset = 5'd31; it.weight_channel_offset = 5'd31;
    it.accumulate = 1'b0;
    run_checked(it);
    it.pad_top = 3'd0; it.pad_left = 3'd1; it.accumulate = 1'b1;
    run_checked(it);
    it.channel_count = 6'd0;
    run_checked(it);
    it.channel_count = 6'd63; it.accumulate = 1'b0;
    run_checked(it);
    read_some(6);
  endtask

  task automatic test_saturation();
    logic [5:0] g [8];
    in_item_t it;
    g = '{6'd8, 6'd8, 6'd1, 6'd1, 6'd8, 6'd8, 6'd1, 6'd1};
    write_geometry(g);
    for (int i = 0; i < 64; i++) begin
      it = rand_item(ACT_LOAD_ACT);
      it.row = 5'(i / 8); it.col = 5'(i % 8); it.channel = 5'd0; it.value = 16'sh8000;
      send_item(it);
      it.action = ACT_LOAD_WGT;
      send_item(it);
      it.channel = 5'd1; it.value = 16'sh7fff;
      send_item(it);
    end
    it = rand_item(ACT_RUN);
    it.pad_top = 3'd0; it.pad_left = 3'd0; it.channel_count = 6'd1;
    it.input_channel_offset = 5'd0; it.weight_channel_offset = 5'd0;
    it.accumulate = 1'b0;
    for (int i = 0; i < 10; i++) begin
      run_checked(it);
      it.accumulate = 1'b1;
    end
    read_some(1);
    it.weight_channel_offset = 5'd1;
    for (int i = 0; i < 18; i++) run_checked(it);
    read_some(1);
  endtask

  task automatic test_geometry_extremes();
    logic [5:0] g [8];
    in_item_t it;
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: g = '{6'd0, 6'd0, 6'd2, 6'd2, 6'd2, 6'd2, 6'd0, 6'd0};
        1: g = '{6'd63, 6'd63, 6'd1, 6'd1, 6'd15, 6'd15, 6'd7, 6'd7};
        2: g = '{6'd1, 6'd1, 6'd0, 6'd3, 6'd1, 6'd1, 6'd1, 6'd1};
        3: g = '{6'd5, 6'd5, 6'd63, 6'd1, 6'd0, 6'd0, 6'd4, 6'd4};
        default: g = '{6'd32, 6'd32, 6'd1, 6'd32, 6'd1, 6'd1, 6'd1, 6'd4};
      endcase
      write_geometry(g);
      it = rand_item(ACT_RUN);
      it.channel_count = 6'($urandom_range(1, 2));
      run_checked(it);
      it.accumulate = 1'b1;
      run_checked(it);
      read_some(3);
    end
  endtask

  task automatic random_geometry();
    logic [5:0] g [8];
    g[REG_IN_ROWS] = 6'($urandom_range(1, 8));
    g[REG_IN_COLS] = 6'($urandom_range(1, 8));
    g[REG_OUT_ROWS] = 6'($urandom_range(1, 4));
    g[REG_OUT_COLS] = 6'($urandom_range(1, 4));
    g[REG_KER_ROWS] = 6'($urandom_range(1, 4));
    g[REG_KER_COLS] = 6'($urandom_range(1, 4));
    g[REG_ROW_STEP] = 6'($urandom_range(0, 4));
    g[REG_COL_STEP] = 6'($urandom_range(0, 4));
    write_geometry(g);
  endtask

  task automatic test_random();
    in_item_t it;
    int phase_end;
    int next_geom;
    for (int p = 0; p < 3; p++) begin
      send_pct = (p == 0) ? 28 : (p == 1) ? 68 : 0;
      recv_pct = (p == 0) ? 68 : (p == 1) ? 28 : 0;
      phase_end = items_sent + 150;
      next_geom = items_sent;
      while (items_sent < phase_end) begin
        if (items_sent >= next_geom) begin
          random_geometry();
          next_geom = items_sent + 120;
        end
        if ($urandom_range(99) < 70) begin
          it = rand_item(ACT_RUN);
          it.channel_count = ($urandom_range(15) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(0, 4));
          run_checked(it);
          read_some($urandom_range(0, 4));
        end else begin
          case ($urandom_range(2))
            0: send_item(rand_item(ACT_LOAD_ACT));
            1: send_item(rand_item(ACT_LOAD_WGT));
            default: read_some(1);
          endcase
        end
      end
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    cycles = 0;
    send_pct = 28;
    recv_pct = 68;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    geom = '{6'd32, 6'd32, 6'd32, 6'd32, 6'd3, 6'd3, 6'd1, 6'd1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_geometry_extremes();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("depthwise_conv2d_engine_unit_tb passed");
    end else begin
      $display("depthwise_conv2d_engine_unit_tb failed");
    end
    $finish;
  end

endmodule
